[rtl/core/rce_pkg.sv]
`default_nettype none
package rce_pkg;

    // Coder bounds and limits
    localparam logic [31:0] TOP_BOUND    = 32'h0100_0000;
    localparam logic [31:0] BOTTOM_BOUND = 32'h0001_0000;
    localparam int          MAX_RAW_BITS = 16;
    localparam int          OUT_LIMIT    = 48;
    localparam int          CNT_W        = 6;
    localparam int          N_W          = 6;

    // Opcodes
    localparam logic [1:0] OP_SYMBOL = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul;
        logic apply;
        logic raw_apply;
        logic next_bit;
        logic renorm;
        logic flush_emit;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       bad_sym;
        logic       cnt_zero;
        logic       last_bit;
        logic       div_last;
        logic       q_zero;
        logic       raw_q_zero;
        logic       renorm_go;
        logic       emit_ok;
        logic       pend_valid;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

[rtl/core/rce_datapath.sv]
`default_nettype none
module rce_datapath
    import rce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [71:0] i_s_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,
    output logic             o_m_tlast
);

    logic [1:0]       r_op;
    logic [15:0]      r_cum, r_freq, r_tot, r_bits;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_low, r_range, r_wc, r_cap;
    logic [N_W-1:0]   r_n;
    logic [15:0]      r_rem;
    logic [31:0]      r_dvd, r_q;
    logic [4:0]       r_dcnt;
    logic [31:0]      r_p_low;
    logic [47:0]      r_p_rng;
    logic             r_pv, r_pd_past;
    logic [7:0]       r_pd_byte;
    logic [31:0]      r_pd_idx;
    logic             r_ov, r_o_past, r_o_last;
    logic [7:0]       r_o_byte;
    logic [31:0]      r_o_idx;

    logic [CNT_W-1:0] in_cnt;
    logic [16:0]      trial;
    logic             ge;
    logic [31:0]      high, rng_c, raw_q, raw_add;
    logic             diff, brk, out_free, emit, past;
    logic [CNT_W-1:0] bit_pos;
    logic             raw_bit;

    // Raw-bit count, saturated
    always_comb begin
        in_cnt = {1'b0, i_s_tdata[70:66]};
        if (in_cnt > CNT_W'(MAX_RAW_BITS)) begin
            in_cnt = CNT_W'(MAX_RAW_BITS);
        end
    end

    // Divider step, renormalization test and raw-bit select
    assign trial   = {r_rem, r_dvd[31]};
    assign ge      = trial >= {1'b0, r_tot};
    assign high    = r_low + r_range;
    assign diff    = (r_low ^ high) >= TOP_BOUND;
    assign brk     = diff && (r_range >= BOTTOM_BOUND);
    assign rng_c   = diff ? ((32'd0 - r_low) & (BOTTOM_BOUND - 32'd1)) : r_range;
    assign bit_pos = r_cnt - CNT_W'(1);
    assign raw_bit = (bit_pos < CNT_W'(16)) ? r_bits[bit_pos[3:0]] : 1'b0;
    assign raw_q   = {1'b0, r_range[31:1]};
    assign raw_add = raw_bit ? raw_q : 32'd0;

    assign out_free = !r_ov || i_m_tready;
    assign emit     = i_cmd.renorm || i_cmd.flush_emit;
    assign past     = r_wc >= r_cap;

    always_comb begin
        o_status.op         = r_op;
        o_status.bad_sym    = (r_tot == 16'd0) || (r_freq == 16'd0);
        o_status.cnt_zero   = r_cnt == '0;
        o_status.last_bit   = r_cnt == CNT_W'(1);
        o_status.div_last   = r_dcnt == 5'd31;
        o_status.q_zero     = r_q == 32'd0;
        o_status.raw_q_zero = raw_q == 32'd0;
        o_status.renorm_go  = !brk && (r_n < N_W'(OUT_LIMIT));
        o_status.emit_ok    = !r_pv || out_free;
        o_status.pend_valid = r_pv;
        o_status.out_free   = out_free;
    end

    // Item fields and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
        if (i_cmd.load) begin
            r_op   <= i_s_tdata[1:0];
            r_cum  <= i_s_tdata[17:2];
            r_freq <= i_s_tdata[33:18];
            r_tot  <= i_s_tdata[49:34];
            r_bits <= i_s_tdata[65:50];
            r_cnt  <= in_cnt;
        end else if (i_cmd.next_bit) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd  <= r_range;
            r_rem  <= '0;
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? 16'(trial - {1'b0, r_tot}) : trial[15:0];
            r_q    <= {r_q[30:0], ge};
            r_dvd  <= {r_dvd[30:0], 1'b0};
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (i_cmd.mul) begin
            r_p_low <= 32'(r_cum * r_q);
            r_p_rng <= r_q * r_freq;
        end
    end

    // Coder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_range <= '1;
            r_wc    <= '0;
            r_n     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_n <= '0;
            end
            if (i_cmd.apply) begin
                r_low   <= r_low + r_p_low;
                r_range <= (r_p_rng[47:32] != 16'd0) ? 32'hFFFF_FFFF : r_p_rng[31:0];
            end else if (i_cmd.raw_apply) begin
                r_low   <= r_low + raw_add;
                r_range <= raw_q;
            end else if (i_cmd.renorm) begin
                r_low   <= {r_low[23:0], 8'd0};
                r_range <= {rng_c[23:0], 8'd0};
            end else if (i_cmd.flush_emit) begin
                r_low <= {r_low[23:0], 8'd0};
            end
            if (emit) begin
                r_wc <= r_wc + 32'd1;
                r_n  <= r_n + N_W'(1);
            end
        end
    end

    // Pending byte: held until it is known whether it ends the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (emit) begin
            r_pv <= 1'b1;
        end else if (i_cmd.finish) begin
            r_pv <= 1'b0;
        end
        if (emit) begin
            r_pd_byte <= r_low[31:24];
            r_pd_idx  <= r_wc;
            r_pd_past <= past;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((emit && r_pv) || i_cmd.finish) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
        if ((emit && r_pv) || i_cmd.finish) begin
            r_o_byte <= r_pd_byte;
            r_o_idx  <= r_pd_idx;
            r_o_past <= r_pd_past;
            r_o_last <= i_cmd.finish;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'd0, r_o_past, r_o_idx, r_o_byte};
    assign o_m_tlast  = r_o_last;

endmodule
`default_nettype wire

[rtl/core/rce_ctrl.sv]
`default_nettype none
module rce_ctrl
    import rce_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_APPLY  = 4'd4;
    localparam logic [3:0] S_RAW    = 4'd5;
    localparam logic [3:0] S_RENORM = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_fk, n_fk;

    assign o_s_tready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_fk    = r_fk;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_fk = 2'd0;
                if (i_status.op == OP_SYMBOL) begin
                    if (i_status.bad_sym) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else if (i_status.op == OP_RAW) begin
                    n_state = i_status.cnt_zero ? S_FIN : S_RAW;
                end else if (i_status.op == OP_FLUSH) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.q_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_RENORM;
            end
            S_RAW: begin
                if (i_status.raw_q_zero) begin
                    o_cmd.next_bit = 1'b1;
                    n_state        = i_status.last_bit ? S_FIN : S_RAW;
                end else begin
                    o_cmd.raw_apply = 1'b1;
                    n_state         = S_RENORM;
                end
            end
            S_RENORM: begin
                if (!i_status.renorm_go) begin
                    if (i_status.op == OP_RAW) begin
                        o_cmd.next_bit = 1'b1;
                        n_state        = i_status.last_bit ? S_FIN : S_RAW;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_status.emit_ok) begin
                    o_cmd.renorm = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_status.emit_ok) begin
                    o_cmd.flush_emit = 1'b1;
                    n_fk             = r_fk + 2'd1;
                    if (r_fk == 2'd3) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fk    <= '0;
        end else begin
            r_state <= n_state;
            r_fk    <= n_fk;
        end
    end

endmodule
`default_nettype wire

[rtl/core/range_coder_encoder_core.sv]
// Carryless 32-bit range encoder.
// Slave stream takes one request per item: tdata holds opcode, cum, freq,
// total, raw bits and bit count. Master stream returns one request per
// code byte with its stream position and an overflow flag; tlast marks the
// final byte caused by an item. The config channel writes the capacity.
// A symbol passes through decode, 32 steps of the one-bit-per-cycle
// restoring divider, multiply, apply, any byte emissions, the closing
// renormalization check and finish. A raw bit is applied and its bytes
// emitted, or it is skipped, between decode and finish. One item is in
// flight at a time; s_tready is high only while the controller is idle.
// Bytes of an item are held one deep until the next byte or the end of the
// item decides tlast, then moved to the output register. A stalled receiver
// holds the output register and the encoder waits at its next emission.
// Reset (synchronous, active low) sets low to 0, range to all ones, the
// byte counter and capacity to 0, and empties both byte registers.
`default_nettype none
module range_coder_encoder_core
    import rce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], sym_cum[17:2], sym_freq[33:18], sym_total[49:34],
    // bit_values[65:50], bit_count[70:66]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0], byte_index[39:8], beyond_capacity[40]
    output logic [47:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    rce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rce_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    // No byte may be left pending while a new item can be taken
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !status.pend_valid)
        else $error("pending byte while idle");

    // Emissions only when the pending byte has somewhere to go
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.renorm || cmd.flush_emit) |-> status.emit_ok)
        else $error("emission without room");

    // The finish command always loads a tlast byte into the output register
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> (m_tvalid && m_tlast))
        else $error("finish without last byte");

endmodule
`default_nettype wire

[dv/tb_range_coder_encoder_core.sv]
`default_nettype none
module tb_range_coder_encoder_core;
    import rce_pkg::*;

    // One code byte as seen on the master stream
    typedef struct packed {
        logic [7:0]  code_byte;
        logic [31:0] pos;
        logic        past_cap;
        logic        last;
    } t_code_byte;

    // One request on the slave stream
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cum;
        logic [15:0] freq;
        logic [15:0] tot;
        logic [15:0] bits;
        logic [4:0]  nbits;
    } t_item;

    // Directed row: item plus an optional typed-in expectation for its first byte
    typedef struct {
        t_item       item;
        logic        has_fixed;
        t_code_byte  fixed;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    range_coder_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state
    logic [31:0] pred_low;
    logic [31:0] pred_range;
    logic [31:0] pred_count;
    logic [31:0] pred_cap;

    t_code_byte  bytes_due[$];
    t_code_byte  fixed_due[$];
    int          fail_cnt;
    bit          rx_hold;
    bit          hold_req;
    int          rx_wait;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Emit the top byte of low into the expected stream
    task automatic push_byte(inout int nb);
        t_code_byte b;
        if (nb >= OUT_LIMIT) return;
        b.code_byte = pred_low[31:24];
        b.pos       = pred_count;
        b.past_cap  = (pred_count >= pred_cap);
        b.last      = 1'b0;
        bytes_due.push_back(b);
        pred_count = pred_count + 32'd1;
        nb++;
    endtask

    task automatic code_symbol(input logic [31:0] cum, input logic [31:0] freq,
                               input logic [31:0] tot, inout int nb);
        logic [31:0] q;
        logic [63:0] prod;
        logic [31:0] hi;
        if (tot == 0 || freq == 0) return;
        q = pred_range / tot;
        if (q == 0) return;
        pred_low   = pred_low + cum * q;
        prod       = {32'd0, q} * {32'd0, freq};
        pred_range = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        // renormalize
        while (nb < OUT_LIMIT) begin
            hi = pred_low + pred_range;
            if ((pred_low ^ hi) >= TOP_BOUND) begin
                if (pred_range >= BOTTOM_BOUND) break;
                pred_range = (32'd0 - pred_low) & (BOTTOM_BOUND - 32'd1);
            end
            push_byte(nb);
            pred_low   = pred_low << 8;
            pred_range = pred_range << 8;
        end
    endtask

    // Work out all bytes one item causes
    task automatic predict_item(input t_item it);
        int nb;
        int cnt;
        nb = 0;
        case (it.op)
            OP_SYMBOL: code_symbol(32'(it.cum), 32'(it.freq), 32'(it.tot), nb);
            OP_RAW: begin
                cnt = (it.nbits > MAX_RAW_BITS) ? MAX_RAW_BITS : it.nbits;
                for (int i = cnt; i > 0; i--)
                    code_symbol({31'd0, it.bits[i-1]}, 32'd1, 32'd2, nb);
            end
            OP_FLUSH: begin
                for (int k = 0; k < 4; k++) begin
                    push_byte(nb);
                    pred_low = pred_low << 8;
                end
            end
            default: ;
        endcase
        if (nb > 0) bytes_due[$].last = 1'b1;
    endtask

    function automatic logic [71:0] pack_item(input t_item it);
        return {1'b0, it.nbits, it.bits, it.tot, it.freq, it.cum, it.op};
    endfunction

    // Valid stays up when the next request follows with no gap
    task automatic send_item(input t_item it, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic drain(input int extra);
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bytes_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [31:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pred_cap = cap;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item mk(input logic [1:0] op, input logic [15:0] cum,
                                 input logic [15:0] freq, input logic [15:0] tot,
                                 input logic [15:0] bits, input logic [4:0] nbits);
        t_item it;
        it.op = op; it.cum = cum; it.freq = freq; it.tot = tot;
        it.bits = bits; it.nbits = nbits;
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    sel;
        sel = $urandom_range(0, 99);
        it.bits  = 16'($urandom);
        it.nbits = 5'($urandom_range(0, 16));
        it.op    = OP_SYMBOL;
        it.tot   = 16'($urandom_range(2, 65535));
        it.cum   = 16'($urandom_range(0, it.tot - 1));
        it.freq  = 16'($urandom_range(1, it.tot - it.cum));
        if (sel < 55) it.op = OP_SYMBOL;
        else if (sel < 80) it.op = OP_RAW;
        else if (sel < 88) it.op = OP_FLUSH;
        else if (sel < 91) it.op = 2'd3;
        else if (sel < 94) it.nbits = 5'($urandom_range(17, 31));
        else if (sel < 97) begin
            // inconsistent symbol, raw field values
            it.cum = 16'($urandom); it.freq = 16'($urandom); it.tot = 16'($urandom);
        end else begin
            it.op = OP_RAW; it.nbits = 5'($urandom);
        end
        if (sel >= 91 && sel < 94) it.op = OP_RAW;
        return it;
    endfunction

    // Receiver: random wait after each byte plus one long hold-off
    always @(posedge i_clk) begin
        t_code_byte got;
        t_code_byte want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[39:8], m_tdata[40], m_tlast};
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected byte, actual %h", $time, got);
                    fail_cnt++;
                end else begin
                    want = bytes_due.pop_front();
                    if (fixed_due.size() != 0 && fixed_due[0].pos == got.pos) begin
                        if (fixed_due[0] != got) begin
                            $display("%0t: table row expected %h actual %h",
                                     $time, fixed_due[0], got);
                            fail_cnt++;
                        end
                        void'(fixed_due.pop_front());
                    end
                    if (want.code_byte != got.code_byte || want.pos != got.pos ||
                        want.past_cap != got.past_cap || want.last != got.last) begin
                        $display("%0t: byte expected %h actual %h", $time, want, got);
                        fail_cnt++;
                    end
                end
                rx_wait = $urandom_range(0, 18);
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_row tbl[$];
        t_row r;
        logic [31:0] caps[6];
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        fail_cnt    = 0;
        rx_hold     = 1'b0;
        hold_req    = 1'b0;
        pred_low = 32'd0; pred_range = 32'hFFFF_FFFF;
        pred_count = 32'd0; pred_cap = 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; flush right after reset gives four zero bytes past capacity 0
        r.has_fixed = 1'b1;
        r.item = mk(OP_FLUSH, 0, 0, 0, 0, 0);
        r.fixed = '{code_byte: 8'h00, pos: 32'd0, past_cap: 1'b1, last: 1'b0};
        tbl.push_back(r);
        r.has_fixed = 1'b0;
        tbl.push_back('{mk(OP_SYMBOL, 0, 1, 65535, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 65534, 1, 65535, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 0, 65535, 65535, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 0, 0, 100, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 3, 5, 0, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 65535, 65535, 2, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 40000, 40000, 50000, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_RAW, 0, 0, 0, 16'hFFFF, 16), 1'b0, '0});
        tbl.push_back('{mk(OP_RAW, 0, 0, 0, 16'h0000, 16), 1'b0, '0});
        tbl.push_back('{mk(OP_RAW, 0, 0, 0, 16'hA5C3, 31), 1'b0, '0});
        tbl.push_back('{mk(OP_RAW, 0, 0, 0, 16'h1234, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_RAW, 0, 0, 0, 16'h0001, 1), 1'b0, '0});
        tbl.push_back('{mk(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31), 1'b0, '0});
        tbl.push_back('{mk(OP_SYMBOL, 1, 1, 3, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_FLUSH, 0, 0, 0, 0, 0), 1'b0, '0});
        for (int i = 0; i < 4; i++)
            tbl.push_back('{mk(OP_SYMBOL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0), 1'b0, '0});
        tbl.push_back('{mk(OP_FLUSH, 0, 0, 0, 0, 0), 1'b0, '0});

        foreach (tbl[i]) begin
            if (tbl[i].has_fixed) fixed_due.push_back(tbl[i].fixed);
            send_item(tbl[i].item, 1'b1);
        end
        drain(200);

        // Random phases across capacity settings, extremes included
        caps[0] = 32'hFFFF_FFFF;
        caps[1] = pred_count + 32'd40;
        caps[2] = 32'd0;
        caps[3] = pred_count + 32'd200;
        caps[4] = 32'h8000_0000;
        caps[5] = 32'hFFFF_FFFF;
        for (int ph = 0; ph < 6; ph++) begin
            set_capacity(ph == 3 ? pred_count + 32'd200 :
                         ph == 1 ? pred_count + 32'd40 : caps[ph]);
            for (int n = 0; n < 60; n++) begin
                // long receiver hold-off while items keep coming
                if (ph == 2 && n == 10) hold_req = 1'b1;
                // sender waits for every expected byte
                if (n == 30) drain(0);
                send_item(rand_item(), (n % 20) < 14);
            end
            drain(200);
        end

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Long hold-off counted here, in cycles
    initial begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Timeout
    initial begin
        #10000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/rce_pkg.sv
rtl/core/rce_datapath.sv
rtl/core/rce_ctrl.sv
rtl/core/range_coder_encoder_core.sv
dv/tb_range_coder_encoder_core.sv
